/* hdl/rgbhsv_pkg.sv */
// ----------------------------------------------------------------------------
// rgbhsv_pkg: shared types and constants for the RGB to HSV pixel converter
// Division lane layout, cell payload and the one-bit restoring division step.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  localparam int CHAN_W   = 8;
  localparam int HUE_W    = 15;
  localparam int QUO_W    = 15;               // quotient bits, one per cell
  localparam int DEN_W    = 9;                // twice an 8-bit channel
  localparam int REM_W    = DEN_W;
  localparam int NUM_W    = REM_W + QUO_W;    // full dividend width
  localparam int OFF_W    = 11;               // sector offset times delta, up to 1530
  localparam int DIV_CELLS = QUO_W;
  localparam int NUM_STAGES = DIV_CELLS + 1;  // entry stage plus the division cells

  localparam int HUE_SECTOR = 3840;           // 60 degrees in 1/64 degree units
  localparam int HUE_FULL   = 23040;          // 360 degrees
  localparam int SAT_SCALE  = 255;

  // One long division in flight: partial remainder, dividend bits still to
  // bring down, divisor and quotient collected so far.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } div_t;

  typedef struct packed {
    div_t              hdiv;
    div_t              sdiv;
    logic [CHAN_W-1:0] brightness;
  } stage_t;

  // Pipeline control between neighbor stages.
  typedef struct packed {
    logic valid;
    logic en;
  } ctl_t;

  function automatic div_t div_step(div_t d);
    logic [REM_W:0] t;
    logic [REM_W:0] diff;
    div_t           o;
    t     = {d.rem, d.num[QUO_W-1]};
    diff  = t - {1'b0, d.den};
    o     = d;
    o.num = {d.num[QUO_W-2:0], 1'b0};
    if (t >= {1'b0, d.den}) begin
      o.rem = diff[REM_W-1:0];
      o.quo = {d.quo[QUO_W-2:0], 1'b1};
    end else begin
      o.rem = t[REM_W-1:0];
      o.quo = {d.quo[QUO_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

/* hdl/rgbhsv_front.sv */
// ----------------------------------------------------------------------------
// rgbhsv_front: entry stage of the converter
// Finds max, min and delta, picks the hue sector and sets up both dividends.
// ----------------------------------------------------------------------------
module rgbhsv_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         valid_in,
  input  logic                         en,
  input  logic [rgbhsv_pkg::CHAN_W-1:0] red,
  input  logic [rgbhsv_pkg::CHAN_W-1:0] green,
  input  logic [rgbhsv_pkg::CHAN_W-1:0] blue,
  output logic                         valid,
  output rgbhsv_pkg::stage_t           stage
);

  logic [rgbhsv_pkg::CHAN_W-1:0] mx, mn, delta;
  logic [rgbhsv_pkg::OFF_W:0]    off;
  logic [rgbhsv_pkg::NUM_W-1:0]  hue_n, sat_n;
  rgbhsv_pkg::stage_t            stage_next;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;
    delta = mx - mn;

    // ties go to red, then green
    priority if (mx == red) begin
      if (green >= blue) off = 12'(green) - 12'(blue);
      else               off = 12'(6) * 12'(delta) - (12'(blue) - 12'(green));
    end else if (mx == green) begin
      off = 12'(2) * 12'(delta) + 12'(blue) - 12'(red);
    end else begin
      off = 12'(4) * 12'(delta) + 12'(red) - 12'(green);
    end

    hue_n = rgbhsv_pkg::NUM_W'(32'(off) * 32'(2 * rgbhsv_pkg::HUE_SECTOR)
                               + 32'(delta));
    sat_n = rgbhsv_pkg::NUM_W'(32'(delta) * 32'(2 * rgbhsv_pkg::SAT_SCALE) + 32'(mx));

    stage_next.brightness = mx;
    if (delta == '0) begin
      // grey pixel: 0 / 1 yields zero hue and saturation
      stage_next.hdiv = '{rem: '0, num: '0, den: rgbhsv_pkg::DEN_W'(1), quo: '0};
      stage_next.sdiv = '{rem: '0, num: '0, den: rgbhsv_pkg::DEN_W'(1), quo: '0};
    end else begin
      stage_next.hdiv.rem = hue_n[rgbhsv_pkg::NUM_W-1:rgbhsv_pkg::QUO_W];
      stage_next.hdiv.num = hue_n[rgbhsv_pkg::QUO_W-1:0];
      stage_next.hdiv.den = {delta, 1'b0};
      stage_next.hdiv.quo = '0;
      stage_next.sdiv.rem = sat_n[rgbhsv_pkg::NUM_W-1:rgbhsv_pkg::QUO_W];
      stage_next.sdiv.num = sat_n[rgbhsv_pkg::QUO_W-1:0];
      stage_next.sdiv.den = {mx, 1'b0};
      stage_next.sdiv.quo = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
    if (en) begin
      stage <= stage_next;
    end
  end

endmodule

/* hdl/rgbhsv_div_cell.sv */
// ----------------------------------------------------------------------------
// rgbhsv_div_cell: one cell of the division chain
// Retires one quotient bit of the hue and the saturation division per request.
// ----------------------------------------------------------------------------
module rgbhsv_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  rgbhsv_pkg::ctl_t   ctl,
  input  rgbhsv_pkg::stage_t stage_in,
  output logic               valid,
  output rgbhsv_pkg::stage_t stage
);

  rgbhsv_pkg::stage_t stage_next;

  always_comb begin
    stage_next.hdiv       = rgbhsv_pkg::div_step(stage_in.hdiv);
    stage_next.sdiv       = rgbhsv_pkg::div_step(stage_in.sdiv);
    stage_next.brightness = stage_in.brightness;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.en) begin
      valid <= ctl.valid;
    end
    if (ctl.en) begin
      stage <= stage_next;
    end
  end

endmodule

/* hdl/rgb_to_hsv_pixel.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel: 8-bit RGB to HSV pixel converter
// Entry stage followed by a chain of restoring division cells.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------
//  pixel   | pix_valid / pix_ready | red, green, blue (8 bits each)
//  result  | hsv_valid / hsv_ready | hue (15), saturation (8), brightness (8)
//
//  One pixel per clock while pix_ready is high; the entry stage loads on the
//  accepting edge, then each of the 15 division cells registers the request
//  and retires one quotient bit.
//  Synchronous reset empties every stage; no other state.
//  A stalled result holds in the last cell; earlier stages keep filling
//  bubbles, and pix_ready drops only when every stage is full.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pix_valid,
  output logic                          pix_ready,
  input  logic [rgbhsv_pkg::CHAN_W-1:0] red,
  input  logic [rgbhsv_pkg::CHAN_W-1:0] green,
  input  logic [rgbhsv_pkg::CHAN_W-1:0] blue,
  output logic                          hsv_valid,
  input  logic                          hsv_ready,
  output logic [rgbhsv_pkg::HUE_W-1:0]  hue,
  output logic [rgbhsv_pkg::CHAN_W-1:0] saturation,
  output logic [rgbhsv_pkg::CHAN_W-1:0] brightness
);

  logic               vld [rgbhsv_pkg::NUM_STAGES];
  logic               en  [rgbhsv_pkg::NUM_STAGES];
  rgbhsv_pkg::stage_t stg [rgbhsv_pkg::NUM_STAGES];
  rgbhsv_pkg::stage_t last;

  // advance a stage when it is empty or its neighbor takes its content
  always_comb begin
    en[rgbhsv_pkg::NUM_STAGES-1] = !vld[rgbhsv_pkg::NUM_STAGES-1] || hsv_ready;
    for (int k = rgbhsv_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign pix_ready = en[0];

  rgbhsv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .valid_in (pix_valid),
    .en       (en[0]),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .valid    (vld[0]),
    .stage    (stg[0])
  );

  for (genvar k = 1; k < rgbhsv_pkg::NUM_STAGES; k++) begin : g_cell
    rgbhsv_pkg::ctl_t ctl;
    assign ctl.valid = vld[k-1];
    assign ctl.en    = en[k];
    rgbhsv_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .stage_in (stg[k-1]),
      .valid    (vld[k]),
      .stage    (stg[k])
    );
  end

  assign last      = stg[rgbhsv_pkg::NUM_STAGES-1];
  assign hsv_valid = vld[rgbhsv_pkg::NUM_STAGES-1];

  // wrap a full turn after rounding
  always_comb begin
    if (last.hdiv.quo >= rgbhsv_pkg::HUE_W'(rgbhsv_pkg::HUE_FULL)) begin
      hue = last.hdiv.quo - rgbhsv_pkg::HUE_W'(rgbhsv_pkg::HUE_FULL);
    end else begin
      hue = last.hdiv.quo;
    end
  end

  assign saturation = last.sdiv.quo[rgbhsv_pkg::CHAN_W-1:0];
  assign brightness = last.brightness;

`ifndef SYNTHESIS
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> (last.hdiv.rem < last.hdiv.den) && (last.sdiv.rem < last.sdiv.den))
    else $error("division remainder not below divisor");

  a_black_zero: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && (brightness == '0) |-> (hue == '0) && (saturation == '0))
    else $error("black pixel with nonzero hue or saturation");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> (hue < rgbhsv_pkg::HUE_W'(rgbhsv_pkg::HUE_FULL)))
    else $error("hue out of range");

  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    vld[0] && !en[0] |=> vld[0] && $stable(stg[0]))
    else $error("entry stage lost a held request");

  a_sat_fits: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> (last.sdiv.quo[rgbhsv_pkg::QUO_W-1:rgbhsv_pkg::CHAN_W] == '0))
    else $error("saturation quotient exceeds 8 bits");
`endif

endmodule
